@@ rtl/core/fdse_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash download session engine package
// Shared phase codes, command bytes, queue entry and result types.
// ----------------------------------------------------------------------------
package fdse_pkg;

    typedef enum logic [2:0] {
        PH_SESSION = 3'd0,
        PH_REQUEST = 3'd1,
        PH_DATA    = 3'd2,
        PH_EXIT    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SUB_IDLE  = 2'd0,
        SUB_ARMED = 2'd1,
        SUB_RECV  = 2'd2
    } t_sub;

    // host commands and responses
    localparam logic [7:0] CMD_SESSION   = 8'h10;
    localparam logic [7:0] CMD_REQUEST   = 8'h34;
    localparam logic [7:0] CMD_DATA      = 8'h36;
    localparam logic [7:0] CMD_EXIT      = 8'h37;
    localparam logic [7:0] RSP_REFUSE    = 8'h7F;
    localparam logic [7:0] RSP_SESSION   = 8'h20;
    localparam logic [7:0] RSP_HEADER    = 8'h44;
    localparam logic [7:0] RSP_DATA_DONE = 8'h46;
    localparam logic [7:0] RSP_EXIT      = 8'h47;

    localparam logic [31:0] MARK_WAIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] MARK_START      = 32'h5555_5555;
    localparam logic [31:0] MARK_ADDR_RESET = 32'h0800_4000;

    localparam logic [3:0] HDR_LAST     = 4'd11;
    localparam logic [2:0] SECTOR_INFO  = 3'd1;
    localparam logic [2:0] SECTOR_IMAGE = 3'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MARK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ADDRESS = 1'b1;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int STEP_W      = 3;

    typedef enum logic [2:0] {
        JOB_SEND        = 3'd0,  // one response byte
        JOB_POLL_START  = 3'd1,  // erase info sector, answer session
        JOB_ERASE_IMAGE = 3'd2,  // erase image sector
        JOB_EXIT        = 3'd3,  // answer exit, system reset
        JOB_PROG        = 3'd4,  // program one image word
        JOB_EMPTY_DONE  = 3'd5,  // empty image: erase, answer, info record
        JOB_LAST_DONE   = 3'd6   // answer, last image word and info record
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  tx;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] first;
        logic [31:0] entry;
        logic [31:0] size;
    } t_job;

    typedef enum logic [1:0] {
        OUT_SEND  = 2'd0,
        OUT_ERASE = 2'd1,
        OUT_PROG  = 2'd2,
        OUT_RESET = 2'd3
    } t_out_kind;

    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  tx;
        logic [2:0]  sector;
        logic [31:0] addr;
        logic [31:0] data;
        logic        last;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [STEP_W-1:0] job_len(input t_job_kind k);
        logic [STEP_W-1:0] n;
        unique case (k)
            JOB_POLL_START, JOB_EXIT:        n = 3'd2;
            JOB_EMPTY_DONE, JOB_LAST_DONE:   n = 3'd6;
            default:                         n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/flash_download_session_engine.sv @@
// ----------------------------------------------------------------------------
// Flash download session engine
// Runs the session, header, data and exit phases of an image download.
// ----------------------------------------------------------------------------
// Flow: an accepted item's job is written into the job queue, and the result
// sequencer then registers its first result when its output register is free.
// Throughput: one item per cycle while the two-entry job queue has room; the
// result sequencer emits one result per cycle while the output is ready, and
// an item that causes results yields 1 to 6 (image word 1, final image byte 6).
// Reset: synchronous, active low; phase to session, counters and header words
// cleared, update_mark to 0xFFFFFFFF, mark_address to 0x08004000.
module flash_download_session_engine #(
    parameter int MAX_IMAGE_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [7:0] tx_byte, [10:8] sector,
                                     // [42:11] prog_address, [74:43] prog_data
    output logic [1:0]  o_m_tuser,   // [1:0] out_kind
    output logic        o_m_tlast,
    input  logic        i_cfg_wen,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fdse_pkg::*;

    logic      push, pop;
    t_job      push_job, head_job;
    t_q_status q_stat;
    t_result   res;
    logic      mark_wen, addr_wen;

    assign mark_wen = i_cfg_wen && (i_cfg_index == CFG_UPDATE_MARK);
    assign addr_wen = i_cfg_wen && (i_cfg_index == CFG_MARK_ADDRESS);

    fdse_front #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (i_s_tuser[0]),
        .i_rx_byte   (i_s_tdata),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_job       (push_job),
        .i_mark_wen  (mark_wen),
        .i_mark_data (i_cfg_data)
    );

    fdse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_stat)
    );

    fdse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_stat.empty),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_res       (res),
        .i_addr_wen  (addr_wen),
        .i_addr_data (i_cfg_data)
    );

    assign o_m_tdata = {5'b00000, res.data, res.addr, res.sector, res.tx};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

    a_reset_ends_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == OUT_RESET)) |-> o_m_tlast)
        else $error("system reset result is not the last of its item");

    a_erase_sector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == OUT_ERASE)) |->
        ((o_m_tdata[10:8] == SECTOR_INFO) || (o_m_tdata[10:8] == SECTOR_IMAGE)))
        else $error("erase of an unexpected sector");

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!q_stat.full || pop))
        else $error("job queue overflow");

    a_idle_after_reset : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

@@ rtl/core/fdse_front.sv @@
// ----------------------------------------------------------------------------
// Session front end
// Accepts bytes and poll ticks, tracks the download phases and queues jobs.
// ----------------------------------------------------------------------------
module fdse_front #(
    parameter int MAX_IMAGE_BYTES = 16384
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_func,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output fdse_pkg::t_job o_job,
    input  logic           i_mark_wen,
    input  logic [31:0]    i_mark_data
);
    import fdse_pkg::*;

    localparam int BC_W = $clog2(MAX_IMAGE_BYTES + 1);

    t_phase            r_phase, n_phase;
    t_sub              r_sub, n_sub;
    logic [3:0]        r_hdr_cnt, n_hdr_cnt;
    logic [31:0]       r_entry, n_entry;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_first, n_first;
    logic [BC_W-1:0]   r_byte_cnt, n_byte_cnt;
    logic [23:0]       r_word_asm, n_word_asm;
    logic [31:0]       r_wr_addr, n_wr_addr;
    logic [31:0]       r_update_mark, n_update_mark;

    logic              acc;
    logic              active;
    logic              ev_poll_arm, ev_poll_start;
    logic              ev_cmd, ev_hdr, ev_data;
    logic [7:0]        want;
    logic              cmd_ok;
    logic              hdr_last, oversize;
    logic [1:0]        pos;
    logic [31:0]       word;
    logic [BC_W-1:0]   bc_inc;
    logic              data_done, word_full;
    logic              job_valid;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign active  = (r_phase == PH_SESSION) || (r_phase == PH_REQUEST) ||
                     (r_phase == PH_DATA) || (r_phase == PH_EXIT);

    // classify the item
    assign ev_poll_arm   = i_func && active && (r_sub == SUB_IDLE) &&
                           ((r_phase != PH_SESSION) || (r_update_mark == MARK_WAIT));
    assign ev_poll_start = i_func && (r_phase == PH_SESSION) && (r_sub == SUB_IDLE) &&
                           (r_update_mark == MARK_START);
    assign ev_cmd  = !i_func && active && (r_sub == SUB_ARMED);
    assign ev_hdr  = !i_func && (r_sub == SUB_RECV) && (r_phase == PH_REQUEST);
    assign ev_data = !i_func && (r_sub == SUB_RECV) && (r_phase == PH_DATA);

    always_comb begin
        unique case (r_phase)
            PH_SESSION: want = CMD_SESSION;
            PH_REQUEST: want = CMD_REQUEST;
            PH_DATA:    want = CMD_DATA;
            default:    want = CMD_EXIT;
        endcase
    end

    assign cmd_ok   = (i_rx_byte == want);
    assign hdr_last = (r_hdr_cnt == HDR_LAST);
    assign oversize = (r_size > 32'(MAX_IMAGE_BYTES));

    assign pos       = r_byte_cnt[1:0];
    assign word      = {8'h00, r_word_asm} | ({24'h0, i_rx_byte} << {pos, 3'b000});
    assign bc_inc    = r_byte_cnt + 1'b1;
    assign data_done = ({{(32-BC_W){1'b0}}, bc_inc} >= r_size);
    assign word_full = (pos == 2'd3) || data_done;

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_sub         = r_sub;
        n_hdr_cnt     = r_hdr_cnt;
        n_entry       = r_entry;
        n_size        = r_size;
        n_first       = r_first;
        n_byte_cnt    = r_byte_cnt;
        n_word_asm    = r_word_asm;
        n_wr_addr     = r_wr_addr;
        n_update_mark = r_update_mark;
        if (i_mark_wen) begin
            n_update_mark = i_mark_data;
        end
        if (acc) begin
            if (ev_poll_arm) begin
                n_sub = SUB_ARMED;
            end else if (ev_poll_start) begin
                n_update_mark = MARK_WAIT;
                n_phase       = PH_REQUEST;
            end else if (ev_cmd) begin
                if (!cmd_ok) begin
                    n_phase = PH_SESSION;
                    n_sub   = SUB_IDLE;
                end else begin
                    unique case (r_phase)
                        PH_SESSION: begin
                            n_phase = PH_REQUEST;
                            n_sub   = SUB_IDLE;
                        end
                        PH_REQUEST: begin
                            n_hdr_cnt = 4'd0;
                            n_sub     = SUB_RECV;
                        end
                        PH_DATA: begin
                            n_byte_cnt = '0;
                            n_word_asm = '0;
                            n_wr_addr  = r_first;
                            if (r_size == 32'd0) begin
                                n_update_mark = MARK_WAIT;
                                n_phase       = PH_EXIT;
                                n_sub         = SUB_IDLE;
                            end else begin
                                n_sub = SUB_RECV;
                            end
                        end
                        default: begin
                            n_phase = PH_DONE;
                            n_sub   = SUB_IDLE;
                        end
                    endcase
                end
            end else if (ev_hdr) begin
                // header is big-endian: entry, size, first address
                if (r_hdr_cnt < 4'd4) begin
                    n_entry = {r_entry[23:0], i_rx_byte};
                end else if (r_hdr_cnt < 4'd8) begin
                    n_size = {r_size[23:0], i_rx_byte};
                end else begin
                    n_first = {r_first[23:0], i_rx_byte};
                end
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (hdr_last) begin
                    n_hdr_cnt = 4'd0;
                    n_phase   = oversize ? PH_SESSION : PH_DATA;
                    n_sub     = SUB_IDLE;
                end
            end else if (ev_data) begin
                n_byte_cnt = bc_inc;
                if (word_full) begin
                    n_wr_addr  = r_wr_addr + 32'd4;
                    n_word_asm = '0;
                    if (data_done) begin
                        n_update_mark = MARK_WAIT;
                        n_phase       = PH_EXIT;
                        n_sub         = SUB_IDLE;
                    end
                end else begin
                    n_word_asm = word[23:0];
                end
            end
        end
    end

    // job for the back end
    always_comb begin
        job_valid   = 1'b0;
        o_job       = '0;
        o_job.kind  = JOB_SEND;
        o_job.first = r_first;
        o_job.entry = r_entry;
        o_job.size  = r_size;
        o_job.addr  = r_wr_addr;
        o_job.data  = word;
        if (ev_poll_start) begin
            job_valid  = 1'b1;
            o_job.kind = JOB_POLL_START;
        end else if (ev_cmd) begin
            if (!cmd_ok) begin
                job_valid = 1'b1;
                o_job.tx  = RSP_REFUSE;
            end else begin
                unique case (r_phase)
                    PH_SESSION: begin
                        job_valid = 1'b1;
                        o_job.tx  = RSP_SESSION;
                    end
                    PH_REQUEST: begin
                        job_valid = 1'b0;
                    end
                    PH_DATA: begin
                        job_valid  = 1'b1;
                        o_job.kind = (r_size == 32'd0) ? JOB_EMPTY_DONE : JOB_ERASE_IMAGE;
                    end
                    default: begin
                        job_valid  = 1'b1;
                        o_job.kind = JOB_EXIT;
                    end
                endcase
            end
        end else if (ev_hdr && hdr_last) begin
            job_valid = 1'b1;
            o_job.tx  = oversize ? RSP_REFUSE : RSP_HEADER;
        end else if (ev_data && word_full) begin
            job_valid  = 1'b1;
            o_job.kind = data_done ? JOB_LAST_DONE : JOB_PROG;
        end
    end

    assign o_push = acc && job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SESSION;
            r_sub         <= SUB_IDLE;
            r_hdr_cnt     <= '0;
            r_entry       <= '0;
            r_size        <= '0;
            r_first       <= '0;
            r_byte_cnt    <= '0;
            r_word_asm    <= '0;
            r_wr_addr     <= '0;
            r_update_mark <= MARK_WAIT;
        end else begin
            r_phase       <= n_phase;
            r_sub         <= n_sub;
            r_hdr_cnt     <= n_hdr_cnt;
            r_entry       <= n_entry;
            r_size        <= n_size;
            r_first       <= n_first;
            r_byte_cnt    <= n_byte_cnt;
            r_word_asm    <= n_word_asm;
            r_wr_addr     <= n_wr_addr;
            r_update_mark <= n_update_mark;
        end
    end

endmodule

@@ rtl/core/fdse_queue.sv @@
// ----------------------------------------------------------------------------
// Job queue
// Short register queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module fdse_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fdse_pkg::t_job      i_job,
    input  logic                i_pop,
    output fdse_pkg::t_job      o_head,
    output fdse_pkg::t_q_status o_status
);
    import fdse_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_head          = r_mem[r_rptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/fdse_back.sv @@
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each queued job into its results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fdse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdse_pkg::t_job    i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output fdse_pkg::t_result o_res,
    input  logic              i_addr_wen,
    input  logic [31:0]       i_addr_data
);
    import fdse_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid;
    t_result           r_res, n_res;
    logic [31:0]       r_mark_addr;
    logic [STEP_W-1:0] len;
    logic              step_last;
    logic              load;
    logic [31:0]       rec_addr, rec_data;

    assign len       = job_len(i_job.kind);
    assign step_last = (r_step == len - 1'b1);
    assign load      = !i_empty && (!r_valid || i_ready);
    assign o_pop     = load && step_last;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_comb begin
        n_step = r_step;
        if (load) begin
            n_step = step_last ? '0 : r_step + 1'b1;
        end
    end

    // info record: first address, entry point, size
    always_comb begin
        unique case (r_step)
            3'd3:    begin rec_addr = r_mark_addr;          rec_data = i_job.first; end
            3'd4:    begin rec_addr = r_mark_addr + 32'd4;  rec_data = i_job.entry; end
            default: begin rec_addr = r_mark_addr + 32'd8;  rec_data = i_job.size;  end
        endcase
    end

    always_comb begin
        n_res      = '0;
        n_res.kind = OUT_SEND;
        n_res.last = step_last;
        unique case (i_job.kind)
            JOB_SEND: begin
                n_res.tx = i_job.tx;
            end
            JOB_POLL_START: begin
                if (r_step == 3'd0) begin
                    n_res.kind   = OUT_ERASE;
                    n_res.sector = SECTOR_INFO;
                end else begin
                    n_res.tx = RSP_SESSION;
                end
            end
            JOB_ERASE_IMAGE: begin
                n_res.kind   = OUT_ERASE;
                n_res.sector = SECTOR_IMAGE;
            end
            JOB_EXIT: begin
                if (r_step == 3'd0) begin
                    n_res.tx = RSP_EXIT;
                end else begin
                    n_res.kind = OUT_RESET;
                end
            end
            JOB_PROG: begin
                n_res.kind = OUT_PROG;
                n_res.addr = i_job.addr;
                n_res.data = i_job.data;
            end
            JOB_EMPTY_DONE, JOB_LAST_DONE: begin
                if (r_step == 3'd0) begin
                    if (i_job.kind == JOB_EMPTY_DONE) begin
                        n_res.kind   = OUT_ERASE;
                        n_res.sector = SECTOR_IMAGE;
                    end else begin
                        n_res.tx = RSP_DATA_DONE;
                    end
                end else if (r_step == 3'd1) begin
                    if (i_job.kind == JOB_EMPTY_DONE) begin
                        n_res.tx = RSP_DATA_DONE;
                    end else begin
                        n_res.kind = OUT_PROG;
                        n_res.addr = i_job.addr;
                        n_res.data = i_job.data;
                    end
                end else if (r_step == 3'd2) begin
                    n_res.kind   = OUT_ERASE;
                    n_res.sector = SECTOR_INFO;
                end else begin
                    n_res.kind = OUT_PROG;
                    n_res.addr = rec_addr;
                    n_res.data = rec_data;
                end
            end
            default: begin
                n_res.tx = i_job.tx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_valid     <= 1'b0;
            r_mark_addr <= MARK_ADDR_RESET;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_addr_wen) begin
                r_mark_addr <= i_addr_data;
            end
        end
    end

endmodule

@@ dv/flash_download_session_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flash download session engine testbench
// Drives link bytes and poll ticks through the session, header, data and exit
// phases, predicts every send, erase, program and reset action, and checks
// each output transaction field by field against the predicted actions.
// ----------------------------------------------------------------------------
module flash_download_session_engine_tb;
    import fdse_pkg::*;

    localparam int IMG_MAX       = 16384;
    localparam int SIZE_CAP      = 64;    // larger images get a wrong byte instead of the data command
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 1000;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_SEND  = 2'd2
    } t_chk;

    typedef struct packed {
        logic       poll;
        logic [7:0] b;
        t_chk       chk;
        logic [7:0] rsp;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;  // [7:0] rx_byte
    logic [0:0]  i_s_tuser   = 1'b0;   // [0] func
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [79:0] o_m_tdata;            // [7:0] tx_byte, [10:8] sector,
                                       // [42:11] prog_address, [74:43] prog_data
    logic [1:0]  o_m_tuser;            // [1:0] out_kind
    logic        o_m_tlast;
    logic        i_cfg_wen   = 1'b0;
    logic [0:0]  i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data  = 32'h0;

    // predicted engine state
    logic [31:0] mk_update  = MARK_WAIT;
    logic [31:0] mk_address = MARK_ADDR_RESET;
    t_phase      st_phase   = PH_SESSION;
    t_sub        st_sub     = SUB_IDLE;
    logic [3:0]  hdr_cnt    = '0;
    logic [31:0] entry_w    = '0;
    logic [31:0] size_w     = '0;
    logic [31:0] first_w    = '0;
    logic [14:0] img_count  = '0;
    logic [23:0] word_acc   = '0;
    logic [31:0] wr_addr    = '0;

    t_result     step_actions[$];
    t_result     due_actions[$];
    t_result     next_due;
    logic        acted;
    logic [95:0] hdr_plan   = '0;

    logic        idle_on    = 1'b1;
    logic        stall_on   = 1'b1;
    logic        calm       = 1'b0;
    logic        finishing  = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          results_seen = 0;

    t_row directed_rows [0:23] = '{
        '{1'b0, CMD_SESSION, CHK_NONE, 8'h00},     // not armed yet: byte is lost
        '{1'b1, 8'hA5,       CHK_NONE, 8'h00},
        '{1'b0, 8'hFF,       CHK_SEND, RSP_REFUSE},
        '{1'b1, 8'h5A,       CHK_NONE, 8'h00},
        '{1'b0, CMD_SESSION, CHK_SEND, RSP_SESSION},
        '{1'b1, 8'h00,       CHK_NONE, 8'h00},
        '{1'b1, 8'hFF,       CHK_NONE, 8'h00},     // already armed
        '{1'b0, CMD_REQUEST, CHK_NONE, 8'h00},
        '{1'b1, 8'hC3,       CHK_NONE, 8'h00},     // poll inside the header
        '{1'b0, 8'hFF,       CHK_NONE, 8'h00},
        '{1'b0, 8'hFF,       CHK_NONE, 8'h00},
        '{1'b0, 8'hFF,       CHK_NONE, 8'h00},
        '{1'b0, 8'hFF,       CHK_NONE, 8'h00},
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},     // size one above the limit
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},
        '{1'b0, 8'h40,       CHK_NONE, 8'h00},
        '{1'b0, 8'h01,       CHK_NONE, 8'h00},
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},
        '{1'b0, 8'h00,       CHK_SEND, RSP_REFUSE},
        '{1'b0, 8'h00,       CHK_NONE, 8'h00},
        '{1'b1, 8'h3C,       CHK_NONE, 8'h00},
        '{1'b0, CMD_EXIT,    CHK_SEND, RSP_REFUSE}  // exit out of phase
    };

    flash_download_session_engine #(
        .MAX_IMAGE_BYTES(IMG_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic note_send(input logic [7:0] b);
        step_actions.push_back(t_result'{OUT_SEND, b, 3'd0, 32'd0, 32'd0, 1'b0});
    endtask

    task automatic note_erase(input logic [2:0] sec);
        step_actions.push_back(t_result'{OUT_ERASE, 8'd0, sec, 32'd0, 32'd0, 1'b0});
        // the update word lives in the info sector
        if (sec == SECTOR_INFO) mk_update = MARK_WAIT;
    endtask

    task automatic note_prog(input logic [31:0] addr, input logic [31:0] data);
        step_actions.push_back(t_result'{OUT_PROG, 8'd0, 3'd0, addr, data, 1'b0});
    endtask

    task automatic refuse_session();
        note_send(RSP_REFUSE);
        st_phase = PH_SESSION;
        st_sub   = SUB_IDLE;
    endtask

    task automatic close_image();
        note_erase(SECTOR_INFO);
        note_prog(mk_address, first_w);
        note_prog(mk_address + 32'd4, entry_w);
        note_prog(mk_address + 32'd8, size_w);
        st_phase = PH_EXIT;
        st_sub   = SUB_IDLE;
    endtask

    // Work out the actions caused by one link byte or poll tick.
    task automatic advance_session(input logic poll, input logic [7:0] b);
        logic [7:0]  want_cmd;
        logic [3:0]  idx;
        logic [1:0]  pos;
        logic [31:0] word;
        logic        done;
        step_actions.delete();
        acted = 1'b1;
        if (poll) begin
            if (st_phase > PH_EXIT || st_sub != SUB_IDLE) begin
                acted = 1'b0;
            end else if (st_phase != PH_SESSION || mk_update == MARK_WAIT) begin
                st_sub = SUB_ARMED;
            end else if (mk_update == MARK_START) begin
                note_erase(SECTOR_INFO);
                note_send(RSP_SESSION);
                st_phase = PH_REQUEST;
            end else begin
                acted = 1'b0;
            end
        end else if (st_phase <= PH_EXIT && st_sub == SUB_ARMED) begin
            case (st_phase)
                PH_SESSION: want_cmd = CMD_SESSION;
                PH_REQUEST: want_cmd = CMD_REQUEST;
                PH_DATA:    want_cmd = CMD_DATA;
                default:    want_cmd = CMD_EXIT;
            endcase
            if (b != want_cmd) begin
                refuse_session();
            end else begin
                case (st_phase)
                    PH_SESSION: begin
                        note_send(RSP_SESSION);
                        st_phase = PH_REQUEST;
                        st_sub   = SUB_IDLE;
                    end
                    PH_REQUEST: begin
                        hdr_cnt = '0;
                        st_sub  = SUB_RECV;
                    end
                    PH_DATA: begin
                        note_erase(SECTOR_IMAGE);
                        img_count = '0;
                        word_acc  = '0;
                        wr_addr   = first_w;
                        if (size_w == 32'd0) begin
                            note_send(RSP_DATA_DONE);
                            close_image();
                        end else begin
                            st_sub = SUB_RECV;
                        end
                    end
                    default: begin
                        note_send(RSP_EXIT);
                        step_actions.push_back(
                            t_result'{OUT_RESET, 8'd0, 3'd0, 32'd0, 32'd0, 1'b0});
                        st_phase = PH_DONE;
                        st_sub   = SUB_IDLE;
                    end
                endcase
            end
        end else if (st_sub == SUB_RECV && st_phase == PH_REQUEST) begin
            // header is big-endian: entry point, size, first address
            idx = hdr_cnt;
            if (idx < 4'd4) entry_w = {entry_w[23:0], b};
            else if (idx < 4'd8) size_w = {size_w[23:0], b};
            else first_w = {first_w[23:0], b};
            hdr_cnt = idx + 4'd1;
            if (idx == HDR_LAST) begin
                hdr_cnt = '0;
                if (size_w > IMG_MAX) begin
                    refuse_session();
                end else begin
                    note_send(RSP_HEADER);
                    st_phase = PH_DATA;
                    st_sub   = SUB_IDLE;
                end
            end
        end else if (st_sub == SUB_RECV && st_phase == PH_DATA) begin
            pos       = img_count[1:0];
            word      = {8'h00, word_acc} | (32'(b) << (8 * pos));
            img_count = img_count + 15'd1;
            done      = 32'(img_count) >= size_w;
            if (pos == 2'd3 || done) begin
                if (done) note_send(RSP_DATA_DONE);
                note_prog(wr_addr, word);
                wr_addr  = wr_addr + 32'd4;
                word_acc = '0;
                if (done) close_image();
            end else begin
                word_acc = word[23:0];
            end
        end else begin
            acted = 1'b0;
        end
        if (step_actions.size() != 0) step_actions[step_actions.size() - 1].last = 1'b1;
    endtask

    // Pick the next item: mostly the one that moves the download forward.
    task automatic pick_next(output logic poll, output logic [7:0] b);
        int          roll;
        int          r;
        logic [31:0] p_entry;
        logic [31:0] p_size;
        logic [31:0] p_first;
        roll = $urandom_range(0, 99);
        poll = 1'b0;
        b    = 8'($urandom_range(0, 255));
        if (st_phase == PH_DONE) begin
            poll = roll[0];
        end else if (st_sub == SUB_ARMED) begin
            if (!finishing && roll < 8) begin
                poll = 1'b1;
            end else if (!finishing && roll < 20) begin
                // stray byte, but never one that ends the run or opens a long image
                if (b == CMD_EXIT || b == CMD_DATA) b = CMD_REQUEST;
            end else begin
                case (st_phase)
                    PH_SESSION: b = CMD_SESSION;
                    PH_REQUEST: b = CMD_REQUEST;
                    PH_DATA:    b = (size_w <= SIZE_CAP) ? CMD_DATA : RSP_REFUSE;
                    default:    b = finishing ? CMD_EXIT : CMD_SESSION;
                endcase
            end
        end else if (!finishing && roll < 8) begin
            poll = roll[0];
        end else if (st_sub == SUB_IDLE) begin
            poll = 1'b1;
        end else if (st_phase == PH_REQUEST) begin
            if (hdr_cnt == 4'd0) begin
                r = $urandom_range(0, 99);
                if (finishing) p_size = $urandom_range(1, 12);
                else if (r < 8) p_size = 32'd0;
                else if (r < 70) p_size = $urandom_range(1, 12);
                else if (r < 85) p_size = $urandom_range(13, 40);
                else if (r < 90) p_size = IMG_MAX;
                else if (r < 95) p_size = IMG_MAX + 1;
                else p_size = $urandom();
                r = $urandom_range(0, 9);
                p_entry = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
                r = $urandom_range(0, 9);
                p_first = (r < 2) ? 32'hFFFF_FFF0 : (r == 2) ? 32'h0 : $urandom();
                hdr_plan = {p_entry, p_size, p_first};
            end
            b = hdr_plan[95 - 8 * hdr_cnt -: 8];
        end
    endtask

    task automatic send_item(input logic poll, input logic [7:0] b,
                             input t_chk chk, input logic [7:0] rsp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        advance_session(poll, b);
        case (chk)
            CHK_MODEL: foreach (step_actions[k]) due_actions.push_back(step_actions[k]);
            CHK_SEND:  due_actions.push_back(
                           t_result'{OUT_SEND, rsp, 3'd0, 32'd0, 32'd0, 1'b1});
            default: ;
        endcase
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= poll;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic push_random_item();
        logic       poll;
        logic [7:0] b;
        pick_next(poll, b);
        send_item(poll, b, CHK_MODEL, 8'h00);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_actions.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int budget);
        int counted;
        counted = 0;
        while (counted < budget) begin
            push_random_item();
            if (acted) counted++;
            if (!calm && $urandom_range(0, 39) == 0) wait_drained();
            if (!calm && $urandom_range(0, 29) == 0) begin
                idle_on  = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
            end
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_UPDATE_MARK) mk_update = value;
        else mk_address = value;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t: action %0d %s: got %h, want %h", $time, results_seen, what, got, want);
    endtask

    // output side: check each transaction, then throttle tready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (due_actions.size() == 0) begin
                    report("unexpected, out_kind", 32'(o_m_tuser), 32'd0);
                end else begin
                    next_due = due_actions.pop_front();
                    if (o_m_tuser != next_due.kind)
                        report("out_kind", 32'(o_m_tuser), 32'(next_due.kind));
                    if (o_m_tdata[7:0] != next_due.tx)
                        report("tx_byte", 32'(o_m_tdata[7:0]), 32'(next_due.tx));
                    if (o_m_tdata[10:8] != next_due.sector)
                        report("sector", 32'(o_m_tdata[10:8]), 32'(next_due.sector));
                    if (o_m_tdata[42:11] != next_due.addr)
                        report("prog_address", o_m_tdata[42:11], next_due.addr);
                    if (o_m_tdata[74:43] != next_due.data)
                        report("prog_data", o_m_tdata[74:43], next_due.data);
                    if (o_m_tdata[79:75] != 5'd0)
                        report("tdata pad", 32'(o_m_tdata[79:75]), 32'd0);
                    if (o_m_tlast != next_due.last)
                        report("last", 32'(o_m_tlast), 32'(next_due.last));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wen) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].poll, directed_rows[k].b,
                      directed_rows[k].chk, directed_rows[k].rsp);
        settle();

        write_reg(CFG_UPDATE_MARK, MARK_WAIT);
        write_reg(CFG_MARK_ADDRESS, 32'h0000_0000);
        run_random(80);
        settle();

        // info record wraps past the top of the address space
        write_reg(CFG_MARK_ADDRESS, 32'hFFFF_FFFC);
        write_reg(CFG_UPDATE_MARK, MARK_START);
        run_random(80);
        settle();

        // unknown mark: the session phase never arms
        write_reg(CFG_UPDATE_MARK, 32'h0000_0000);
        repeat (20) push_random_item();
        settle();

        write_reg(CFG_MARK_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_UPDATE_MARK, MARK_START);
        run_random(60);

        calm     = 1'b1;
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_random(30);

        // drive the session to exit, then check that it stays silent
        finishing = 1'b1;
        while (st_phase != PH_DONE) push_random_item();
        repeat (6) push_random_item();
        settle();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fdse_pkg.sv
rtl/core/fdse_front.sv
rtl/core/fdse_queue.sv
rtl/core/fdse_back.sv
rtl/core/flash_download_session_engine.sv
dv/flash_download_session_engine_tb.sv
